@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle port check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle port check failed.");

// Next-cycle implication that is also checked during reset.
`define CHK_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("Reset port check failed.");

`endif

@@ hw/rtl/hsv565_pkg.sv @@
// Shared types and constants of the HSV to RGB565 converter.
package hsv565_pkg;

  localparam int HUE_W   = 15;
  localparam int SAT_W   = 8;
  localparam int VAL_W   = 8;
  localparam int COLOR_W = 16;
  localparam int IN_TDATA_W = 32;

  localparam int NUM_STG = 6;

  // Reciprocal of 360 for the sector split, exact for any 15-bit dividend.
  localparam int RCP360_W  = 16;
  localparam int RCP360_SH = 24;
  localparam logic [RCP360_W-1:0] RCP360 = 16'd46604;
  localparam int SEXT_W = 7;

  // Reciprocal of 255 for p, exact for any 16-bit dividend.
  localparam int RCP255_W  = 17;
  localparam int RCP255_SH = 24;
  localparam logic [RCP255_W-1:0] RCP255 = 17'd65794;

  // Reciprocal of 255 * 60 for q and t, exact for any dividend below 255 * 15300.
  localparam int RCPQ_W  = 23;
  localparam int RCPQ_SH = 36;
  localparam logic [RCPQ_W-1:0] RCPQ = 23'd4491470;
  localparam int QN_W = 22;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
  } pipe_en_t;

endpackage

@@ hw/rtl/hsv565_split.sv @@
// Hue split: sector number and remainder within the sector, two pipeline stages.
module hsv565_split #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                          clk,
  input  hsv565_pkg::pipe_en_t          en,
  input  logic [hsv565_pkg::HUE_W-1:0]  hue_in,
  input  logic [hsv565_pkg::SAT_W-1:0]  sat_in,
  input  logic [hsv565_pkg::VAL_W-1:0]  val_in,
  output hsv565_pkg::sector_t           sector_r,
  output logic [HUE_FRAC_BITS+5:0]      rem_r,
  output logic [hsv565_pkg::SAT_W-1:0]  sat_r,
  output logic [hsv565_pkg::VAL_W-1:0]  val_r
);
  import hsv565_pkg::*;

  localparam int HW = HUE_W - HUE_FRAC_BITS;
  localparam int PW = HW + RCP360_W;
  localparam int RW = HUE_FRAC_BITS + 6;
  localparam logic [HUE_W-1:0] LOW_MASK = HUE_W'((1 << HUE_FRAC_BITS) - 1);

  logic [HUE_W-1:0] hue1_r;
  logic [SAT_W-1:0] sat1_r;
  logic [VAL_W-1:0] val1_r;
  logic [PW-1:0]    prod1_r;
  logic [PW-1:0]    prod_nxt;

  logic [SEXT_W-1:0] turns;
  logic [15:0]       hdeg;
  logic [8:0]        mdeg;
  logic [5:0]        rdeg;
  sector_t           sector_nxt;
  logic [RW-1:0]     rem_nxt;

  assign prod_nxt = PW'(hue_in >> HUE_FRAC_BITS) * PW'(RCP360);

  always_ff @(posedge clk) begin
    if (en.st1) begin
      hue1_r  <= hue_in;
      sat1_r  <= sat_in;
      val1_r  <= val_in;
      prod1_r <= prod_nxt;
    end
  end

  always_comb begin
    turns = SEXT_W'(prod1_r >> RCP360_SH);
    hdeg  = 16'(hue1_r >> HUE_FRAC_BITS);
    mdeg  = 9'(hdeg - 16'(turns) * 16'd360);
    priority if (mdeg >= 9'd300) begin
      sector_nxt = SEC_M_TO_R;
      rdeg       = 6'(mdeg - 9'd300);
    end else if (mdeg >= 9'd240) begin
      sector_nxt = SEC_B_TO_M;
      rdeg       = 6'(mdeg - 9'd240);
    end else if (mdeg >= 9'd180) begin
      sector_nxt = SEC_C_TO_B;
      rdeg       = 6'(mdeg - 9'd180);
    end else if (mdeg >= 9'd120) begin
      sector_nxt = SEC_G_TO_C;
      rdeg       = 6'(mdeg - 9'd120);
    end else if (mdeg >= 9'd60) begin
      sector_nxt = SEC_Y_TO_G;
      rdeg       = 6'(mdeg - 9'd60);
    end else begin
      sector_nxt = SEC_R_TO_Y;
      rdeg       = 6'(mdeg);
    end
    rem_nxt = (RW'(rdeg) << HUE_FRAC_BITS) | RW'(hue1_r & LOW_MASK);
  end

  always_ff @(posedge clk) begin
    if (en.st2) begin
      sector_r <= sector_nxt;
      rem_r    <= rem_nxt;
      sat_r    <= sat1_r;
      val_r    <= val1_r;
    end
  end

endmodule

@@ hw/rtl/hsv565_chan.sv @@
// Channel terms p, q and t over three pipeline stages.
module hsv565_chan #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                                             clk,
  input  hsv565_pkg::pipe_en_t                             en,
  input  hsv565_pkg::sector_t                              sector_in,
  input  logic [HUE_FRAC_BITS+5:0]                         rem_in,
  input  logic [hsv565_pkg::SAT_W-1:0]                     sat_in,
  input  logic [hsv565_pkg::VAL_W-1:0]                     val_in,
  output hsv565_pkg::sector_t                              sector_r,
  output logic [hsv565_pkg::VAL_W-1:0]                     val_r,
  output logic [7:0]                                       p8_r,
  output logic [hsv565_pkg::QN_W+hsv565_pkg::RCPQ_W-1:0]   qprod_r,
  output logic [hsv565_pkg::QN_W+hsv565_pkg::RCPQ_W-1:0]   tprod_r
);
  import hsv565_pkg::*;

  localparam int RW = HUE_FRAC_BITS + 6;
  localparam int FW = HUE_FRAC_BITS + 14;
  localparam int NW = FW + VAL_W;
  localparam int QPW = QN_W + RCPQ_W;
  localparam int PPW = 16 + RCP255_W;
  localparam logic [RW-1:0] SPAN = RW'(60 << HUE_FRAC_BITS);
  localparam logic [FW-1:0] FULL = FW'(255 * (60 << HUE_FRAC_BITS));

  sector_t        sector3_r, sector4_r;
  logic [VAL_W-1:0] val3_r, val4_r;
  logic [FW-1:0]  rs3_r, rts3_r;
  logic [15:0]    pn3_r;
  logic [QN_W-1:0] qn4_r, tn4_r;
  logic [PPW-1:0] pprod4_r;

  logic [NW-1:0]  qnum, tnum;

  always_ff @(posedge clk) begin
    if (en.st3) begin
      sector3_r <= sector_in;
      val3_r    <= val_in;
      rs3_r     <= FW'(rem_in) * FW'(sat_in);
      rts3_r    <= FW'(SPAN - rem_in) * FW'(sat_in);
      pn3_r     <= 16'(val_in) * 16'(8'd255 - sat_in);
    end
  end

  assign qnum = NW'(val3_r) * NW'(FULL - rs3_r);
  assign tnum = NW'(val3_r) * NW'(FULL - rts3_r);

  always_ff @(posedge clk) begin
    if (en.st4) begin
      sector4_r <= sector3_r;
      val4_r    <= val3_r;
      qn4_r     <= QN_W'(qnum >> HUE_FRAC_BITS);
      tn4_r     <= QN_W'(tnum >> HUE_FRAC_BITS);
      pprod4_r  <= PPW'(pn3_r) * PPW'(RCP255);
    end
  end

  always_ff @(posedge clk) begin
    if (en.st5) begin
      sector_r <= sector4_r;
      val_r    <= val4_r;
      p8_r     <= pprod4_r[RCP255_SH +: 8];
      qprod_r  <= QPW'(qn4_r) * QPW'(RCPQ);
      tprod_r  <= QPW'(tn4_r) * QPW'(RCPQ);
    end
  end

endmodule

@@ hw/rtl/hsv_to_rgb565_unit.sv @@
// Top level of the HSV to RGB565 converter: stage control, channel order and packing.
//
//   Channel  Direction  Handshake                  Payload
//   in_      slave      in_tvalid / in_tready      hue 14:0, saturation 22:15, value 30:23
//   out_     master     out_tvalid / out_tready    RGB565 pixel 15:0
//
// One transaction is accepted per clock unless a full pipeline is stalled at the output.
// The six register stages are the hue split by a reciprocal of 360, the sector
// decode, the products of remainder and saturation, the numerators of q and t,
// their reciprocal divide by 255 times the sector span, and the output register.
// Reset clears only the stage valid bits.
// A stage loads whenever it is empty or the stage after it moves, so a stall at
// the output fills the empty stages before it holds the input.
module hsv_to_rgb565_unit #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: hue_angle[14:0], sat_level[22:15], val_level[30:23], zero pad.
  input  logic [hsv565_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: color_565[15:0].
  output logic [hsv565_pkg::COLOR_W-1:0]      out_tdata
);
  import hsv565_pkg::*;

  localparam int RW  = HUE_FRAC_BITS + 6;
  localparam int QPW = QN_W + RCPQ_W;

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] adv;
  pipe_en_t           en;

  sector_t          sector2, sector5;
  logic [RW-1:0]    rem2;
  logic [SAT_W-1:0] sat2;
  logic [VAL_W-1:0] val2, val5;
  logic [7:0]       p8;
  logic [QPW-1:0]   qprod, tprod;

  logic [7:0]         q8, t8, r8, g8, b8;
  logic [COLOR_W-1:0] color_nxt;
  logic [COLOR_W-1:0] color_r;

  always_comb begin
    adv[NUM_STG-1] = !vld_r[NUM_STG-1] || out_tready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NUM_STG; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign en = '{st1: adv[0], st2: adv[1], st3: adv[2], st4: adv[3], st5: adv[4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  hsv565_split #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_split (
    .clk      (clk),
    .en       (en),
    .hue_in   (in_tdata[HUE_W-1:0]),
    .sat_in   (in_tdata[HUE_W +: SAT_W]),
    .val_in   (in_tdata[HUE_W+SAT_W +: VAL_W]),
    .sector_r (sector2),
    .rem_r    (rem2),
    .sat_r    (sat2),
    .val_r    (val2)
  );

  hsv565_chan #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_chan (
    .clk       (clk),
    .en        (en),
    .sector_in (sector2),
    .rem_in    (rem2),
    .sat_in    (sat2),
    .val_in    (val2),
    .sector_r  (sector5),
    .val_r     (val5),
    .p8_r      (p8),
    .qprod_r   (qprod),
    .tprod_r   (tprod)
  );

  always_comb begin
    q8 = qprod[RCPQ_SH +: 8];
    t8 = tprod[RCPQ_SH +: 8];
    unique case (sector5)
      SEC_R_TO_Y: begin r8 = val5; g8 = t8;   b8 = p8;   end
      SEC_Y_TO_G: begin r8 = q8;   g8 = val5; b8 = p8;   end
      SEC_G_TO_C: begin r8 = p8;   g8 = val5; b8 = t8;   end
      SEC_C_TO_B: begin r8 = p8;   g8 = q8;   b8 = val5; end
      SEC_B_TO_M: begin r8 = t8;   g8 = p8;   b8 = val5; end
      SEC_M_TO_R: begin r8 = val5; g8 = p8;   b8 = q8;   end
      default:    begin r8 = val5; g8 = p8;   b8 = q8;   end
    endcase
    color_nxt = {r8[7:3], g8[7:2], b8[7:3]};
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STG-1]) begin
      color_r <= color_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NUM_STG-1];
  assign out_tdata  = color_r;

endmodule

@@ hw/rtl/hsv565_chk.sv @@
// Port checker for the HSV to RGB565 converter and its bind to the top level.
`include "assert_macros.svh"

module hsv565_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [hsv565_pkg::COLOR_W-1:0]     out_tdata
);

  // A result that is refused stays offered with the same pixel.
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Reset empties the pipeline.
  `CHK_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

  // An empty or draining output stage never holds back the input.
  `CHK_SAME(a_in_free, clk, rst_n, !out_tvalid || out_tready, in_tready)

  // A stalled input means the output is full and refused.
  `CHK_SAME(a_stall_cause, clk, rst_n, !in_tready, out_tvalid && !out_tready)

endmodule

bind hsv_to_rgb565_unit hsv565_chk u_hsv565_chk (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the HSV to RGB565 pixel converter with random stream stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv565_pkg::*;

  localparam int HUE_FRAC_BITS = 6;
  localparam int SPAN = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL = 6 * SPAN;
  localparam int RANDOM_ITEMS = 1130;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [COLOR_W-1:0] out_tdata;

  logic [COLOR_W-1:0] pixel_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  int tx_calm_left = 0;
  int rx_hold_left = 0;

  hsv_to_rgb565_unit #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [COLOR_W-1:0] hsv_pixel(logic [HUE_W-1:0] hue,
                                                    logic [SAT_W-1:0] sat,
                                                    logic [VAL_W-1:0] val);
    longint unsigned h, s, v, full, rem;
    logic [7:0] p8, q8, t8, r8, g8, b8;
    sector_t sector;
    h = hue;
    s = sat;
    v = val;
    if (s == 0) begin
      r8 = val;
      g8 = val;
      b8 = val;
    end else begin
      sector = sector_t'((h / SPAN) % 6);
      rem = h % SPAN;
      full = 255 * SPAN;
      p8 = 8'((v * (255 - s)) / 255);
      q8 = 8'((v * (full - rem * s)) / full);
      t8 = 8'((v * (full - (SPAN - rem) * s)) / full);
      case (sector)
        SEC_R_TO_Y: begin r8 = val; g8 = t8;  b8 = p8;  end
        SEC_Y_TO_G: begin r8 = q8;  g8 = val; b8 = p8;  end
        SEC_G_TO_C: begin r8 = p8;  g8 = val; b8 = t8;  end
        SEC_C_TO_B: begin r8 = p8;  g8 = q8;  b8 = val; end
        SEC_B_TO_M: begin r8 = t8;  g8 = p8;  b8 = val; end
        default:    begin r8 = val; g8 = p8;  b8 = q8;  end
      endcase
    end
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  function automatic int idle_gap();
    int r;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_calm_left = $urandom_range(50, 150);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_color(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                            logic [VAL_W-1:0] val);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, val, sat, hue};
    do @(posedge clk); while (!in_tready);
  endtask

  always @(posedge clk) begin
    int r;
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        out_tready <= 1'b1;
        rx_hold_left <= $urandom_range(100, 200);
      end else if (r < 60) begin
        out_tready <= 1'b1;
        rx_hold_left <= $urandom_range(0, 3);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        rx_hold_left <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        rx_hold_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pixel_q.push_back(hsv_pixel(in_tdata[14:0], in_tdata[22:15], in_tdata[30:23]));
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%t unexpected pixel: expected none, actual %h", $time, out_tdata);
        end else begin
          want = pixel_q.pop_front();
          if (out_tdata !== want) begin
            errors++;
            $display("%t color_565 mismatch: expected %h, actual %h", $time, want, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_gray();
    send_color(15'd0, 8'd0, 8'd255);
    send_color(15'd32767, 8'd0, 8'd0);
    send_color(15'd9000, 8'd0, 8'd170);
  endtask

  task automatic test_sectors();
    for (int k = 0; k < 6; k++)
      send_color(HUE_W'(k * SPAN + SPAN / 2), 8'd255, 8'd255);
    send_color(HUE_W'(SPAN - 1), 8'd200, 8'd231);
    send_color(HUE_W'(SPAN), 8'd200, 8'd231);
  endtask

  task automatic test_hue_wrap();
    send_color(HUE_W'(HUE_FULL), 8'd180, 8'd250);
    send_color(HUE_W'(HUE_FULL + 1), 8'd180, 8'd250);
    send_color(15'd32767, 8'd255, 8'd255);
  endtask

  task automatic test_extremes();
    send_color(15'd0, 8'd255, 8'd0);
    send_color(15'd1234, 8'd1, 8'd255);
    send_color(15'd0, 8'd128, 8'd128);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++)
      send_color(HUE_W'($urandom_range(0, HUE_FULL)), SAT_W'($urandom), VAL_W'($urandom));
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 6; i++)
      send_color(HUE_W'($urandom_range(0, HUE_FULL)), SAT_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic test_random();
    int r;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [VAL_W-1:0] val;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) hue = HUE_W'($urandom_range(0, HUE_FULL));
      else if (r < 90) hue = HUE_W'($urandom_range(0, 6) * SPAN - 1 + $urandom_range(0, 2));
      else hue = HUE_W'($urandom_range(0, 32767));
      r = $urandom_range(0, 99);
      sat = (r < 5) ? 8'd0 : (r < 10) ? 8'd255 : SAT_W'($urandom);
      r = $urandom_range(0, 99);
      val = (r < 5) ? 8'd0 : (r < 10) ? 8'd255 : VAL_W'($urandom);
      send_color(hue, sat, val);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_gray();
    test_sectors();
    test_hue_wrap();
    test_extremes();
    test_drain_pause();
    test_random();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
